/* rtl/homography_point_warp_defines.svh */
// ----------------------------------------------------------------------------
// homography_point_warp_defines.svh
// Assertion macros for the homography point warp block.
// ----------------------------------------------------------------------------
`ifndef HOMOGRAPHY_POINT_WARP_DEFINES_SVH
`define HOMOGRAPHY_POINT_WARP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HPW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hpw: implication check failed");

// next-cycle implication
`define HPW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hpw: next-cycle check failed");

`else

`define HPW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HPW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/hpw_pkg.sv */
// ----------------------------------------------------------------------------
// hpw_pkg
// Shared types and codes of the homography point warp block.
// ----------------------------------------------------------------------------
`default_nettype none

package hpw_pkg;

  // configuration register indexes
  localparam logic [7:0] HPW_REG_A = 8'd0;
  localparam logic [7:0] HPW_REG_B = 8'd1;
  localparam logic [7:0] HPW_REG_C = 8'd2;
  localparam logic [7:0] HPW_REG_D = 8'd3;
  localparam logic [7:0] HPW_REG_E = 8'd4;
  localparam logic [7:0] HPW_REG_F = 8'd5;
  localparam logic [7:0] HPW_REG_G = 8'd6;
  localparam logic [7:0] HPW_REG_H = 8'd7;

  typedef enum logic [1:0] {
    HPW_ST_OK   = 2'd0,
    HPW_ST_ZERO = 2'd1,
    HPW_ST_SAT  = 2'd2
  } hpw_status_t;

  // per-item flags carried alongside the divider data
  typedef struct packed {
    logic zero;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } hpw_flags_t;

endpackage

`default_nettype wire

/* rtl/hpw_div.sv */
// ----------------------------------------------------------------------------
// hpw_div
// Pipelined dual-lane restoring divider, one quotient bit per stage,
// with overflow precheck and round-half-away on the magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module hpw_div
  import hpw_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [COORD_WIDTH+50:0]      num_x,
  input  wire logic [COORD_WIDTH+50:0]      num_y,
  input  wire logic [COORD_WIDTH+32:0]      den,
  input  wire hpw_flags_t                   flags_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [COORD_WIDTH+1:0]            mag_x,
  output logic [COORD_WIDTH+1:0]            mag_y,
  output hpw_flags_t                        flags_out
);

  localparam int QB = COORD_WIDTH + 1;        // quotient bits
  localparam int MW = COORD_WIDTH + 33;       // divisor width
  localparam int NW = MW + 18;                // numerator width
  localparam int DQ = MW + QB;
  localparam int RW = (NW > DQ) ? NW : DQ;    // remainder width
  localparam int NA = QB + 1;                 // precheck + step stages

  typedef struct packed {
    logic [RW-1:0] rx;
    logic [RW-1:0] ry;
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;
    logic [MW-1:0] d;
    hpw_flags_t    fl;
  } dstage_t;

  dstage_t          st_r   [NA];
  dstage_t          st_nxt [NA];
  logic [NA-1:0]    v_r;
  logic [NA-1:0]    rdy;
  logic             rdy_o;
  logic             out_valid_r;
  logic [QB:0]      mag_x_r, mag_x_nxt;
  logic [QB:0]      mag_y_r, mag_y_nxt;
  hpw_flags_t       flags_r;

  // ready ripples back through empty stages
  always_comb begin
    rdy_o       = !out_valid_r || out_ready;
    rdy[NA-1]   = !v_r[NA-1] || rdy_o;
    for (int i = NA - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_ready = rdy[0];

  always_comb begin
    logic [RW-1:0] dsh;
    logic [RW:0]   tx;
    logic [RW:0]   ty;
    logic          inc_x;
    logic          inc_y;
    dsh = '0;
    tx  = '0;
    ty  = '0;
    // precheck: quotient would not fit in QB bits
    st_nxt[0].rx       = RW'(num_x);
    st_nxt[0].ry       = RW'(num_y);
    st_nxt[0].qx       = '0;
    st_nxt[0].qy       = '0;
    st_nxt[0].d        = den;
    st_nxt[0].fl       = flags_in;
    st_nxt[0].fl.ovf_x = RW'(num_x) >= (RW'(den) << QB);
    st_nxt[0].fl.ovf_y = RW'(num_y) >= (RW'(den) << QB);
    // one restoring step per stage, high quotient bit first
    for (int j = 1; j < NA; j++) begin
      st_nxt[j] = st_r[j-1];
      dsh = RW'(st_r[j-1].d) << (QB - j);
      tx  = {1'b0, st_r[j-1].rx} - {1'b0, dsh};
      ty  = {1'b0, st_r[j-1].ry} - {1'b0, dsh};
      if (!tx[RW]) begin
        st_nxt[j].rx         = tx[RW-1:0];
        st_nxt[j].qx[QB - j] = 1'b1;
      end
      if (!ty[RW]) begin
        st_nxt[j].ry         = ty[RW-1:0];
        st_nxt[j].qy[QB - j] = 1'b1;
      end
    end
    // round half away: bump when twice the remainder reaches the divisor
    inc_x     = {st_r[NA-1].rx, 1'b0} >= (RW+1)'(st_r[NA-1].d);
    inc_y     = {st_r[NA-1].ry, 1'b0} >= (RW+1)'(st_r[NA-1].d);
    mag_x_nxt = (QB+1)'(st_r[NA-1].qx) + (QB+1)'(inc_x);
    mag_y_nxt = (QB+1)'(st_r[NA-1].qy) + (QB+1)'(inc_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NA; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
      if (rdy_o) begin
        out_valid_r <= v_r[NA-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      st_r[0] <= st_nxt[0];
    end
    for (int i = 1; i < NA; i++) begin
      if (rdy[i] && v_r[i-1]) begin
        st_r[i] <= st_nxt[i];
      end
    end
    if (rdy_o && v_r[NA-1]) begin
      mag_x_r <= mag_x_nxt;
      mag_y_r <= mag_y_nxt;
      flags_r <= st_r[NA-1].fl;
    end
  end

  assign out_valid = out_valid_r;
  assign mag_x     = mag_x_r;
  assign mag_y     = mag_y_r;
  assign flags_out = flags_r;

endmodule

`default_nettype wire

/* rtl/homography_point_warp.sv */
// ----------------------------------------------------------------------------
// homography_point_warp
// Perspective point warp through a 3x3 homography with h33 fixed at 1.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one point (in_x, in_y), signed
//   Q12.4, per item. Result channel (out_valid/out_ready) returns out_x,
//   out_y (u/w, v/w rounded half away, Q12.4) and out_status: OK, ZERO when
//   w is zero (outputs are 0), SAT when a coordinate clamps.
//   Coefficients a..h are written over cfg_valid/cfg_ready/cfg_index/cfg_data
//   while the block is idle; the user must keep to this, the block does not
//   enforce it. cfg_ready is always high, indexes above 7 drop. The pipeline
//   has one multiply stage, one sum stage, one magnitude stage, a precheck
//   stage, COORD_WIDTH + 1 divider stages (one quotient bit each), a rounding
//   stage and the output register. Throughput is one item per cycle while
//   the receiver does not stall; a stalled receiver holds the output register;
//   ready ripples back through empty stages, so items keep entering until
//   every stage is occupied. Reset (rst_n low, synchronous) empties the
//   pipeline and loads the identity mapping into the coefficient registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "homography_point_warp_defines.svh"

module homography_point_warp
  import hpw_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_y,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0]      out_x,
  output logic signed [COORD_WIDTH-1:0]      out_y,
  output logic [1:0]                         out_status,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [7:0]                    cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int QB = CW + 1;
  localparam int PW = CW + 32;          // product width
  localparam int SW = CW + 34;          // sum width
  localparam int MW = SW - 1;           // magnitude width
  localparam int NW = MW + 18;          // numerator width
  localparam logic signed [SW-1:0] W_ONE   = SW'(64'd1 << 34);
  localparam logic [QB:0]          LIM_POS = (QB+1)'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [QB:0]          LIM_NEG = (QB+1)'(64'd1 << (CW - 1));
  localparam logic [CW-1:0]        MAX_V   = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]        MIN_V   = {1'b1, {(CW-1){1'b0}}};

  // coefficient registers
  logic signed [31:0] coef_a_r, coef_b_r, coef_c_r, coef_d_r;
  logic signed [31:0] coef_e_r, coef_f_r, coef_g_r, coef_h_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= 32'sd65536;
      coef_b_r <= '0;
      coef_c_r <= '0;
      coef_d_r <= '0;
      coef_e_r <= 32'sd65536;
      coef_f_r <= '0;
      coef_g_r <= '0;
      coef_h_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        HPW_REG_A: coef_a_r <= cfg_data;
        HPW_REG_B: coef_b_r <= cfg_data;
        HPW_REG_C: coef_c_r <= cfg_data;
        HPW_REG_D: coef_d_r <= cfg_data;
        HPW_REG_E: coef_e_r <= cfg_data;
        HPW_REG_F: coef_f_r <= cfg_data;
        HPW_REG_G: coef_g_r <= cfg_data;
        HPW_REG_H: coef_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  logic div_in_ready, div_out_valid, rdy_o, out_valid_r;

  assign rdy_o    = !out_valid_r || out_ready;
  assign rdy3     = !v3_r || div_in_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy_o) out_valid_r <= div_out_valid;
    end
  end

  // stage 1: six products
  logic signed [PW-1:0] p_a_r, p_b_r, p_d_r, p_e_r, p_g_r, p_h_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      p_a_r <= coef_a_r * in_x;
      p_b_r <= coef_b_r * in_y;
      p_d_r <= coef_d_r * in_x;
      p_e_r <= coef_e_r * in_y;
      p_g_r <= coef_g_r * in_x;
      p_h_r <= coef_h_r * in_y;
    end
  end

  // stage 2: u, v, w with translation and constant term aligned
  logic signed [SW-1:0] u_r, v_r, w_r, u_nxt, v_nxt, w_nxt;

  always_comb begin
    u_nxt = SW'(p_a_r) + SW'(p_b_r) + (SW'(coef_c_r) <<< 4);
    v_nxt = SW'(p_d_r) + SW'(p_e_r) + (SW'(coef_f_r) <<< 4);
    w_nxt = SW'(p_g_r) + SW'(p_h_r) + W_ONE;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
      w_r <= w_nxt;
    end
  end

  // stage 3: magnitudes and signs
  logic [SW-1:0]  abs_u, abs_v, abs_w;
  logic [NW-1:0]  num_x_r, num_y_r;
  logic [MW-1:0]  den_r;
  hpw_flags_t     fl3_nxt, fl3_r;

  always_comb begin
    abs_u = u_r[SW-1] ? (SW'(0) - u_r) : u_r;
    abs_v = v_r[SW-1] ? (SW'(0) - v_r) : v_r;
    abs_w = w_r[SW-1] ? (SW'(0) - w_r) : w_r;
    fl3_nxt       = '0;
    fl3_nxt.zero  = (w_r == '0);
    fl3_nxt.neg_x = u_r[SW-1] ^ w_r[SW-1];
    fl3_nxt.neg_y = v_r[SW-1] ^ w_r[SW-1];
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      num_x_r <= {abs_u[MW-1:0], 18'd0};
      num_y_r <= {abs_v[MW-1:0], 18'd0};
      den_r   <= abs_w[MW-1:0];
      fl3_r   <= fl3_nxt;
    end
  end

  // divider stages
  logic [QB:0] mag_x, mag_y;
  hpw_flags_t  fl_d;

  hpw_div #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (div_in_ready),
    .num_x     (num_x_r),
    .num_y     (num_y_r),
    .den       (den_r),
    .flags_in  (fl3_r),
    .out_valid (div_out_valid),
    .out_ready (rdy_o),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .flags_out (fl_d)
  );

  // output stage: sign, clamp, status
  logic          sat_x, sat_y;
  logic [QB:0]   neg_mx, neg_my;
  logic [CW-1:0] x_nxt, y_nxt, out_x_r, out_y_r;
  hpw_status_t   st_nxt, status_r;

  always_comb begin
    sat_x  = fl_d.ovf_x || (mag_x > (fl_d.neg_x ? LIM_NEG : LIM_POS));
    sat_y  = fl_d.ovf_y || (mag_y > (fl_d.neg_y ? LIM_NEG : LIM_POS));
    neg_mx = (QB+1)'(0) - mag_x;
    neg_my = (QB+1)'(0) - mag_y;
    if (sat_x) begin
      x_nxt = fl_d.neg_x ? MIN_V : MAX_V;
    end else begin
      x_nxt = fl_d.neg_x ? neg_mx[CW-1:0] : mag_x[CW-1:0];
    end
    if (sat_y) begin
      y_nxt = fl_d.neg_y ? MIN_V : MAX_V;
    end else begin
      y_nxt = fl_d.neg_y ? neg_my[CW-1:0] : mag_y[CW-1:0];
    end
    if (fl_d.zero) begin
      x_nxt  = '0;
      y_nxt  = '0;
      st_nxt = HPW_ST_ZERO;
    end else if (sat_x || sat_y) begin
      st_nxt = HPW_ST_SAT;
    end else begin
      st_nxt = HPW_ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && div_out_valid) begin
      out_x_r  <= x_nxt;
      out_y_r  <= y_nxt;
      status_r <= st_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_status = status_r;

  // input only backs up when every stage holds an item and the receiver stalls
  `HPW_ASSERT_IMP(a_stall_only_full, clk, rst_n, !in_ready, out_valid && !out_ready)
  `HPW_ASSERT_IMP(a_zero_clears, clk, rst_n, out_valid && out_status == HPW_ST_ZERO, out_x == '0 && out_y == '0)
  `HPW_ASSERT_IMP(a_sat_at_limit, clk, rst_n, out_valid && out_status == HPW_ST_SAT, out_x == MAX_V || out_x == MIN_V || out_y == MAX_V || out_y == MIN_V)

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Homography point warp regression
// Drives points through the warp block over valid/ready, with random gaps on
// the input side and random stalls on the result side. Coefficients are
// reloaded between phases. Each result is compared against a bit-exact
// integer predictor: affine and perspective sums, rounded division with ties
// away from zero, clamping, and the zero denominator case.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hpw_pkg::*;

  localparam int CW = 16;
  localparam int CLK_PERIOD = 4;
  localparam int PIPE_LATENCY = CW + 7;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    hpw_status_t          st;
  } warp_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [CW-1:0] in_x = '0;
  logic signed [CW-1:0] in_y = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic [1:0]           out_status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [7:0]           cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  logic signed [31:0] warp_coef [8];
  warp_result_t       expected_warps [$];
  int                 mismatch_count = 0;
  bit                 tx_steady = 1'b0;
  bit                 rx_steady = 1'b0;
  int                 rx_hold = 0;

  homography_point_warp #(.COORD_WIDTH(CW)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_x       (in_x),
    .in_y       (in_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_status (out_status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // rounded magnitude quotient, ties away from zero, clamped to the coord range
  function automatic logic signed [CW-1:0] divide_round_sat(
      input logic signed [127:0] num, input logic signed [127:0] den,
      output bit clamped);
    logic [127:0] mag_n, mag_d, quo, rem, lim;
    bit neg;
    neg = num[127] ^ den[127];
    mag_n = num[127] ? -num : num;
    mag_d = den[127] ? -den : den;
    quo = mag_n / mag_d;
    rem = mag_n % mag_d;
    if ((rem << 1) >= mag_d) quo = quo + 1;
    lim = neg ? (128'd1 << (CW - 1)) : (128'd1 << (CW - 1)) - 1;
    if (quo > lim) begin
      clamped = 1'b1;
      return neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    clamped = 1'b0;
    return neg ? -quo[CW-1:0] : quo[CW-1:0];
  endfunction

  function automatic warp_result_t warp_point(input logic signed [CW-1:0] px,
                                              input logic signed [CW-1:0] py);
    logic signed [127:0] sx, sy, u, v, w;
    warp_result_t r;
    bit cx, cy;
    sx = px;
    sy = py;
    // u, v carry 20 fraction bits, w carries 34
    u = warp_coef[HPW_REG_A] * sx + warp_coef[HPW_REG_B] * sy
      + warp_coef[HPW_REG_C] * 128'sd16;
    v = warp_coef[HPW_REG_D] * sx + warp_coef[HPW_REG_E] * sy
      + warp_coef[HPW_REG_F] * 128'sd16;
    w = warp_coef[HPW_REG_G] * sx + warp_coef[HPW_REG_H] * sy + (128'sd1 <<< 34);
    if (w == 0) begin
      r.px = '0;
      r.py = '0;
      r.st = HPW_ST_ZERO;
      return r;
    end
    r.px = divide_round_sat(u <<< 18, w, cx);
    r.py = divide_round_sat(v <<< 18, w, cy);
    r.st = (cx || cy) ? HPW_ST_SAT : HPW_ST_OK;
    return r;
  endfunction

  task automatic send_point(input logic signed [CW-1:0] px,
                            input logic signed [CW-1:0] py);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x <= px;
    in_y <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_warps.push_back(warp_point(px, py));
  endtask

  // hold input low until every outstanding point has come back
  task automatic drain_pipeline;
    in_valid <= 1'b0;
    while (expected_warps.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= HPW_REG_H) warp_coef[idx] = data;
  endtask

  task automatic load_coefs(input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c, input logic [31:0] d,
                            input logic [31:0] e, input logic [31:0] f,
                            input logic [31:0] g, input logic [31:0] h);
    drain_pipeline();
    write_reg(HPW_REG_A, a);
    write_reg(HPW_REG_B, b);
    write_reg(HPW_REG_C, c);
    write_reg(HPW_REG_D, d);
    write_reg(HPW_REG_E, e);
    write_reg(HPW_REG_F, f);
    write_reg(HPW_REG_G, g);
    write_reg(HPW_REG_H, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_identity;
    send_point(16'sd0, 16'sd0);
    send_point(16'sd32767, -16'sd32768);
    send_point(-16'sd32768, 16'sd32767);
    send_point(-16'sd1, 16'sd1);
    send_point(16'sd32767, 16'sd32767);
    send_point(-16'sd32768, -16'sd32768);
  endtask

  task automatic test_round_half_away;
    // scale by one half: odd coordinates land exactly on a tie
    load_coefs(32'h0000_8000, 32'h0, 32'h0, 32'h0, 32'h0000_8000, 32'h0, 32'h0, 32'h0);
    send_point(16'sd1, -16'sd1);
    send_point(16'sd3, -16'sd3);
    send_point(-16'sd32768, 16'sd32767);
    send_point(16'sd32767, -16'sd5);
  endtask

  task automatic test_zero_denominator;
    // g = 1.0, so x = -1.0 cancels the constant term
    load_coefs(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
               32'h4000_0000, 32'h0);
    send_point(-16'sd16, 16'sd5);
    send_point(-16'sd16, -16'sd32768);
    load_coefs(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
               32'h0, 32'hC000_0000);
    send_point(16'sd123, 16'sd16);
    // w = -1 mirrors the point
    send_point(16'sd500, 16'sd32);
    // nearly singular: tiny w blows both coordinates out
    load_coefs(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
               32'h3FFF_FFFF, 32'h0);
    send_point(-16'sd16, 16'sd100);
  endtask

  task automatic test_saturation;
    load_coefs(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_point(16'sd32767, 16'sd7);
    send_point(-16'sd32768, -16'sd7);
    send_point(16'sd0, 16'sd42);
    load_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_point(16'sd1, -16'sd1);
    send_point(-16'sd1, 16'sd0);
  endtask

  task automatic test_bad_index;
    drain_pipeline();
    // out-of-range indexes must leave the coefficients alone
    write_reg(8'd8, 32'hFFFF_FFFF);
    write_reg(8'hFF, 32'h1234_5678);
    write_reg(8'h80, 32'h0000_0000);
    cfg_valid <= 1'b0;
    send_point(16'sd100, -16'sd200);
    send_point(-16'sd32768, 16'sd32767);
  endtask

  task automatic test_random_warps(input int phases, input int per_phase);
    int kind, shift;
    logic [31:0] cf [8];
    logic signed [CW-1:0] px, py;
    bit neg_g;
    for (int p = 0; p < phases; p++) begin
      kind = p % 5;
      shift = $urandom_range(0, 4);
      neg_g = $urandom_range(0, 1);
      for (int k = 0; k < 8; k++) cf[k] = $urandom;
      case (kind)
        0: begin
          // plausible camera warp: near-affine with mild perspective
          cf[HPW_REG_A] = int'($urandom_range(0, 131072));
          cf[HPW_REG_B] = int'($urandom_range(0, 65536)) - 32768;
          cf[HPW_REG_C] = int'($urandom_range(0, 2000 << 16)) - (1000 << 16);
          cf[HPW_REG_D] = int'($urandom_range(0, 65536)) - 32768;
          cf[HPW_REG_E] = int'($urandom_range(0, 131072));
          cf[HPW_REG_F] = int'($urandom_range(0, 2000 << 16)) - (1000 << 16);
          cf[HPW_REG_G] = int'($urandom_range(0, 1 << 16)) - (1 << 15);
          cf[HPW_REG_H] = int'($urandom_range(0, 1 << 16)) - (1 << 15);
        end
        2: begin
          // singular line at x = -(1 << shift) pixels, or +(1 << shift) when g is negative
          cf[HPW_REG_G] = neg_g ? -(32'sd1 <<< (30 - shift)) : (32'sd1 <<< (30 - shift));
          cf[HPW_REG_H] = '0;
        end
        3: for (int k = 0; k < 8; k++) cf[k] = 32'h7FFF_FFFF;
        4: for (int k = 0; k < 8; k++) cf[k] = 32'h8000_0000;
        default: ;
      endcase
      load_coefs(cf[0], cf[1], cf[2], cf[3], cf[4], cf[5], cf[6], cf[7]);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 9) < 3) begin
          px = int'($urandom_range(0, 2048)) - 1024;
          py = int'($urandom_range(0, 2048)) - 1024;
        end else begin
          px = $urandom;
          py = $urandom;
        end
        if (kind == 2 && $urandom_range(0, 1) == 1) begin
          px = neg_g ? (16'sd16 <<< shift) : -(16'sd16 <<< shift);
          if ($urandom_range(0, 3) == 0) px = px + int'($urandom_range(0, 2)) - 1;
        end
        if (kind == 4 && $urandom_range(0, 4) == 0) py = 16'sd8 - px;
        send_point(px, py);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      out_ready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 3) == 0) rx_hold = pick_gap(1'b0);
    end
  end

  always @(posedge clk) begin
    warp_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_warps.size() == 0) begin
        $error("result with nothing pending: x %0d y %0d status %0d",
               out_x, out_y, out_status);
        mismatch_count++;
      end else begin
        exp_r = expected_warps.pop_front();
        if (out_x !== exp_r.px) begin
          $error("out_x: expected %0d, got %0d", exp_r.px, out_x);
          mismatch_count++;
        end
        if (out_y !== exp_r.py) begin
          $error("out_y: expected %0d, got %0d", exp_r.py, out_y);
          mismatch_count++;
        end
        if (out_status !== exp_r.st) begin
          $error("out_status: expected %0d, got %0d", exp_r.st, out_status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    warp_coef[HPW_REG_A] = 32'sh0001_0000;
    warp_coef[HPW_REG_B] = '0;
    warp_coef[HPW_REG_C] = '0;
    warp_coef[HPW_REG_D] = '0;
    warp_coef[HPW_REG_E] = 32'sh0001_0000;
    warp_coef[HPW_REG_F] = '0;
    warp_coef[HPW_REG_G] = '0;
    warp_coef[HPW_REG_H] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity();
    test_round_half_away();
    test_zero_denominator();
    test_saturation();
    test_bad_index();
    test_random_warps(16, 100);
    drain_pipeline();
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
